>>> rtl/ascii_graymap_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the graymap parser
// Shared wrappers around concurrent assertions; clock and reset are the
// signals named clock and reset in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASCII_GRAYMAP_PARSER_ASSERT_SVH
`define ASCII_GRAYMAP_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGP_CHECK_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("graymap parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define AGP_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("graymap parser check failed");

`endif

>>> rtl/agp_pkg.sv
// ---------------------------------------------------------------------------
// Graymap parser package
// Types, character codes and limits shared by the parser modules.
// ---------------------------------------------------------------------------
package agp_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int QUEUE_DEPTH    = 4;

   // Number magnitudes saturate one above the largest 16-bit value.
   localparam logic [16:0] NUM_SAT       = 17'd65536;
   // A size token carrying a minus sign is stored as this marker.
   localparam logic [16:0] SIZE_NEGATIVE = 17'h1FFFF;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_WIDTH,
      PH_HEIGHT,
      PH_MAX,
      PH_PIXELS,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_BAD_MAGIC   = 3'd0,
      ERR_TRUNCATED   = 3'd1,
      ERR_BAD_MAXIMUM = 3'd2,
      ERR_ZERO_SIZE   = 3'd3,
      ERR_BAD_PIXEL   = 3'd4,
      ERR_TOO_FEW     = 3'd5,
      ERR_OVERSIZE    = 3'd6
   } error_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [11:0] row;
      logic [11:0] column;
      error_type   error_code;
      logic        end_of_image;
   } result_type;

   // Up to two results produced by one byte, packed from the first slot.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

>>> rtl/ascii_graymap_parser.sv
// ---------------------------------------------------------------------------
// Plain-text graymap parser
// Parses a P2 graymap byte stream into a header result, pixel results and
// error results.
// ---------------------------------------------------------------------------
// Usage:
// The req channel carries one file byte per transaction, with req_last_byte
// set on the final byte of the file. The rsp channel carries results: one
// header, then one per pixel in raster order with its row and column, or a
// single error with its code. A byte yields zero, one or two results.
// The first result of a byte is offered once the byte has passed the input
// register and been written into the result queue.
// One byte is accepted every cycle while req_stall is low; the rate is set
// by the single register-to-register parsing step and by the result channel
// draining one result per cycle while rsp_stall is low. A byte with two
// results sends both through a four-entry result queue that absorbs that burst.
// When the receiver stalls, the queue fills and req_stall rises once fewer
// than two entries are free; results are never dropped.
// Reset empties the queue and returns the parser to waiting for the magic
// token. The final byte of each file also returns the parser to that state.
// ---------------------------------------------------------------------------
module ascii_graymap_parser
   import agp_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_req,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_value,
   output logic [12:0] rsp_image_width,
   output logic [12:0] rsp_image_height,
   output logic [11:0] rsp_row,
   output logic [11:0] rsp_column,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_end_of_image
);

   push_type   push;
   logic       room;
   result_type head;

   agp_parse #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte_req  (req_byte_req),
      .req_last_byte (req_last_byte),
      .room          (room),
      .push          (push)
   );

   agp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_value        = head.value;
   assign rsp_image_width  = head.image_width;
   assign rsp_image_height = head.image_height;
   assign rsp_row          = head.row;
   assign rsp_column       = head.column;
   assign rsp_error_code   = head.error_code;
   assign rsp_end_of_image = head.end_of_image;

endmodule

>>> rtl/agp_parse.sv
// ---------------------------------------------------------------------------
// Graymap parser core
// Registers one byte, then tokenizes and checks it combinationally against the
// header and pixel state, pushing up to two results to the queue.
// ---------------------------------------------------------------------------
module agp_parse
   import agp_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_req,
   input  logic       req_last_byte,
   input  logic       room,
   output push_type   push
);

   localparam int          CW   = $clog2(MAX_WIDTH + 1);
   localparam int          RW   = $clog2(MAX_HEIGHT + 1);
   localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
   localparam logic [16:0] MaxH = 17'(MAX_HEIGHT);

   logic          in_vld_ff, in_vld_in;
   logic [7:0]    byte_ff;
   logic          last_ff;
   logic          accept, proc;

   phase_type     phase_ff, phase_in;
   logic          in_tok_ff, in_tok_in;
   logic          in_cmt_ff, in_cmt_in;
   logic [1:0]    mp_ff, mp_in;
   logic [16:0]   num_ff, num_in;
   logic          neg_ff, neg_in;
   logic          de_ff, de_in;
   logic          ts_ff, ts_in;
   logic [16:0]   w_ff, w_in;
   logic [16:0]   h_ff, h_in;
   logic [15:0]   max_ff, max_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic          sp, is_digit, take, fin, negf;
   logic [20:0]   acc;
   logic [16:0]   size_v, col_inc, row_new;
   logic          wrap, last_px;
   logic [31:0]   row_ext, col_ext;
   logic          fin_emit;
   result_type    fin_res, end_res;
   logic          end_err;
   push_type      push_c;

   assign proc      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept ? 1'b1 : (proc ? 1'b0 : in_vld_ff);

   assign sp       = (byte_ff == CH_SPACE) || (byte_ff >= CH_TAB && byte_ff <= CH_CR);
   assign is_digit = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign row_ext  = 32'(row_ff);
   assign col_ext  = 32'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (accept) begin
         byte_ff <= req_byte_req;
         last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         in_tok_ff <= 1'b0;
         in_cmt_ff <= 1'b0;
         mp_ff     <= 2'd0;
         num_ff    <= 17'd0;
         neg_ff    <= 1'b0;
         de_ff     <= 1'b0;
         ts_ff     <= 1'b0;
         w_ff      <= 17'd0;
         h_ff      <= 17'd0;
         max_ff    <= 16'd0;
         row_ff    <= '0;
         col_ff    <= '0;
      end else if (proc) begin
         phase_ff  <= phase_in;
         in_tok_ff <= in_tok_in;
         in_cmt_ff <= in_cmt_in;
         mp_ff     <= mp_in;
         num_ff    <= num_in;
         neg_ff    <= neg_in;
         de_ff     <= de_in;
         ts_ff     <= ts_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         max_ff    <= max_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      in_tok_in = in_tok_ff;
      in_cmt_in = in_cmt_ff;
      mp_in     = mp_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      de_in     = de_ff;
      ts_in     = ts_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      max_in    = max_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      take      = 1'b0;
      fin       = 1'b0;
      fin_emit  = 1'b0;
      end_err   = 1'b0;
      fin_res   = '0;
      end_res   = '0;
      acc       = '0;

      // Character classification: comment, token body or token start.
      if (phase_ff != PH_IDLE) begin
         if (in_cmt_ff) begin
            if (byte_ff == CH_LF) begin
               in_cmt_in = 1'b0;
            end
         end else if (in_tok_ff) begin
            if (sp) begin
               fin = 1'b1;
            end else begin
               take = 1'b1;
            end
         end else if (byte_ff == CH_HASH) begin
            in_cmt_in = 1'b1;
         end else if (!sp) begin
            in_tok_in = 1'b1;
            take      = 1'b1;
            mp_in     = 2'd0;
            num_in    = 17'd0;
            neg_in    = 1'b0;
            de_in     = 1'b0;
            ts_in     = 1'b0;
         end
      end

      if (take) begin
         if (mp_in == 2'd0 && byte_ff == CH_P) begin
            mp_in = 2'd1;
         end else if (mp_in == 2'd1 && byte_ff == CH_TWO) begin
            mp_in = 2'd2;
         end else begin
            mp_in = 2'd3;
         end
         if (!ts_in && (byte_ff == CH_PLUS || byte_ff == CH_MINUS)) begin
            ts_in  = 1'b1;
            neg_in = (byte_ff == CH_MINUS);
         end else begin
            ts_in = 1'b1;
            if (!de_in) begin
               if (is_digit) begin
                  acc    = (21'(num_in) << 3) + (21'(num_in) << 1)
                           + 21'(byte_ff[3:0]);
                  num_in = (acc > 21'(NUM_SAT)) ? NUM_SAT : acc[16:0];
               end else begin
                  de_in = 1'b1;
               end
            end
         end
      end

      // The final byte closes any token still open.
      if (last_ff && phase_ff != PH_IDLE && in_tok_in) begin
         fin = 1'b1;
      end

      negf    = neg_in && (num_in != 17'd0);
      size_v  = negf ? SIZE_NEGATIVE : num_in;
      col_inc = 17'(col_ff) + 17'd1;
      wrap    = col_inc >= w_ff;
      row_new = wrap ? (17'(row_ff) + 17'd1) : 17'(row_ff);
      last_px = row_new >= h_ff;

      if (fin) begin
         in_tok_in = 1'b0;
         case (phase_ff)
            PH_MAGIC: begin
               if (mp_in != 2'd2) begin
                  fin_emit           = 1'b1;
                  fin_res.kind       = KIND_ERROR;
                  fin_res.error_code = ERR_BAD_MAGIC;
                  phase_in           = PH_IDLE;
               end else begin
                  phase_in = PH_WIDTH;
               end
            end
            PH_WIDTH: begin
               w_in     = size_v;
               phase_in = PH_HEIGHT;
            end
            PH_HEIGHT: begin
               h_in     = size_v;
               phase_in = PH_MAX;
            end
            PH_MAX: begin
               fin_emit = 1'b1;
               if (negf || num_in == 17'd0 || num_in[16]) begin
                  fin_res.kind       = KIND_ERROR;
                  fin_res.error_code = ERR_BAD_MAXIMUM;
                  phase_in           = PH_IDLE;
               end else if (w_ff == 17'd0 || h_ff == 17'd0) begin
                  fin_res.kind       = KIND_ERROR;
                  fin_res.error_code = ERR_ZERO_SIZE;
                  phase_in           = PH_IDLE;
               end else if (w_ff > MaxW || h_ff > MaxH) begin
                  fin_res.kind       = KIND_ERROR;
                  fin_res.error_code = ERR_OVERSIZE;
                  phase_in           = PH_IDLE;
               end else begin
                  max_in               = num_in[15:0];
                  row_in               = '0;
                  col_in               = '0;
                  fin_res.kind         = KIND_HEADER;
                  fin_res.value        = num_in[15:0];
                  fin_res.image_width  = w_ff[12:0];
                  fin_res.image_height = h_ff[12:0];
                  phase_in             = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               fin_emit = 1'b1;
               if (negf || num_in > {1'b0, max_ff}) begin
                  fin_res.kind       = KIND_ERROR;
                  fin_res.error_code = ERR_BAD_PIXEL;
                  phase_in           = PH_IDLE;
               end else begin
                  col_in               = wrap ? '0 : col_inc[CW-1:0];
                  row_in               = row_new[RW-1:0];
                  fin_res.kind         = KIND_PIXEL;
                  fin_res.value        = num_in[15:0];
                  fin_res.image_width  = w_ff[12:0];
                  fin_res.image_height = h_ff[12:0];
                  fin_res.row          = row_ext[11:0];
                  fin_res.column       = col_ext[11:0];
                  fin_res.end_of_image = last_px;
                  if (last_px) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // End of file: report an unfinished image, then return to reset state.
      if (last_ff) begin
         end_res.kind = KIND_ERROR;
         case (phase_in)
            PH_MAGIC: begin
               end_err            = 1'b1;
               end_res.error_code = ERR_BAD_MAGIC;
            end
            PH_WIDTH, PH_HEIGHT, PH_MAX: begin
               end_err            = 1'b1;
               end_res.error_code = ERR_TRUNCATED;
            end
            PH_PIXELS: begin
               end_err            = 1'b1;
               end_res.error_code = ERR_TOO_FEW;
            end
            default: begin
            end
         endcase
         phase_in  = PH_MAGIC;
         in_tok_in = 1'b0;
         in_cmt_in = 1'b0;
         mp_in     = 2'd0;
         num_in    = 17'd0;
         neg_in    = 1'b0;
         de_in     = 1'b0;
         ts_in     = 1'b0;
         w_in      = 17'd0;
         h_in      = 17'd0;
         max_in    = 16'd0;
         row_in    = '0;
         col_in    = '0;
      end

      push_c        = '0;
      push_c.first  = fin_emit ? fin_res : end_res;
      push_c.second = end_res;
      if (proc) begin
         push_c.count = 2'(fin_emit) + 2'(end_err);
      end
   end

   assign push = push_c;

   `include "ascii_graymap_parser_assert.svh"

   `AGP_CHECK_NOW(p_idle_quiet, proc && phase_ff == PH_IDLE && !last_ff, push.count == 2'd0)
   `AGP_CHECK_NEXT(p_last_resets, proc && last_ff, phase_ff == PH_MAGIC && !in_tok_ff && !in_cmt_ff)
   `AGP_CHECK_NOW(p_second_is_error, push.count == 2'd2, push.second.kind == KIND_ERROR)

endmodule

>>> rtl/agp_queue.sv
// ---------------------------------------------------------------------------
// Graymap parser result queue
// Small register queue that takes up to two results per cycle and hands
// one per cycle to the result channel while rsp_stall is low.
// ---------------------------------------------------------------------------
module agp_queue
   import agp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   result_type    mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop;

   assign pop       = (cnt_ff != '0) && !rsp_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign head      = mem_ff[rp_ff];
   // Room means a full two-result transaction can still be stored.
   assign room      = cnt_ff <= CW'(QUEUE_DEPTH - 2);

   assign wp_in  = wp_ff + PW'(push.count);
   assign rp_in  = rp_ff + PW'(pop);
   assign cnt_in = cnt_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wp_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wp_ff + PW'(1)] <= push.second;
      end
   end

   `include "ascii_graymap_parser_assert.svh"

   `AGP_CHECK_NOW(q_no_overflow, push.count != 2'd0, cnt_ff <= CW'(QUEUE_DEPTH - 2))
   `AGP_CHECK_NEXT(q_pop_drains, pop && push.count == 2'd0, cnt_ff == $past(cnt_ff) - CW'(1))

endmodule
